// ===== hw/rtl/c2ep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package c2ep_pkg;

  // fixed-point layout of the log and angle paths
  localparam int LOG_FRAC   = 24;
  localparam int MANT_FRAC  = 30;
  localparam int GUARD_BITS = 16;
  localparam int SQRT_STEPS = 32;
  localparam int LOG_STEPS  = LOG_FRAC;

  // stage positions along the eta path, input register is stage 0
  localparam int ST_K      = 3;
  localparam int ST_A      = ST_K + SQRT_STEPS + 1;
  localparam int ST_LOG    = ST_A + 1 + LOG_STEPS;
  localparam int ST_OUT    = ST_LOG + 3;
  localparam int LATENCY   = ST_OUT + 1;

  localparam logic [27:0] LN2_Q28     = 28'd186065279;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  localparam logic signed [15:0] ETA_POS_END = 16'sh7FFF;
  localparam logic signed [15:0] ETA_NEG_END = 16'sh8000;

  // atan(2^-i) in radians, 30 fraction bits
  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  typedef struct packed {
    logic last;
    logic z_pos;
    logic z_neg;
    logic r_zero;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/c2ep_log2.sv =====
`timescale 1ns / 1ps
`default_nettype none

// log2 by normalise then repeated squaring, one result bit per stage
module c2ep_log2 import c2ep_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [63:0] val_i,
  output logic [29:0]      log_o
);

  logic [MANT_FRAC:0]   m_q [0:LOG_STEPS];
  logic [29:0]          r_q [0:LOG_STEPS];

  logic [5:0]           top_n;
  logic [63:0]          norm;

  always_comb begin
    top_n = '0;
    for (int b = 0; b < 64; b++) begin
      if (val_i[b]) top_n = 6'(b);
    end
    if (top_n > 6'(MANT_FRAC)) begin
      norm = val_i >> (top_n - 6'(MANT_FRAC));
    end else begin
      norm = val_i << (6'(MANT_FRAC) - top_n);
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0] <= norm[MANT_FRAC:0];
    r_q[0] <= {top_n, {LOG_FRAC{1'b0}}};
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
    logic [2*MANT_FRAC+1:0] sq;
    logic [MANT_FRAC+1:0]   t;
    assign sq = m_q[j] * m_q[j];
    assign t  = sq[2*MANT_FRAC+1:MANT_FRAC];
    always_ff @(posedge clk_i) begin
      if (t[MANT_FRAC+1]) begin
        m_q[j+1] <= t[MANT_FRAC+1:1];
        r_q[j+1] <= r_q[j] | (30'd1 << (LOG_STEPS - 1 - j));
      end else begin
        m_q[j+1] <= t[MANT_FRAC:0];
        r_q[j+1] <= r_q[j];
      end
    end
  end

  assign log_o = r_q[LOG_STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/cartesian_to_eta_phi.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                           transfer
// hit in    start_i, x_pos_i, y_pos_i, z_pos_i, last_hit_i  start_i high, busy_o low
// result    done_o, eta_o, phi_o, eta_saturated_o,          done_o high for one cycle
//           last_out_o
//
// one hit is taken every cycle; busy_o stays low
// a result sits on the ports while done_o is high, once its hit has passed through every stage:
// the 32-step square root followed by the 24-step log2 squaring chain;
// phi runs alongside in a cordic
// reset clears only the valid line, so a fresh pipeline drops nothing it never took
// the receiver cannot stall, so every stage advances on every clock

module cartesian_to_eta_phi import c2ep_pkg::*; #(
  parameter int COORD_WIDTH     = 18,
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_pos_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_pos_i,
  input  wire logic signed [COORD_WIDTH-1:0] z_pos_i,
  input  wire logic                          last_hit_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [15:0]                 eta_o,
  output logic signed [14:0]                 phi_o,
  output logic                               eta_saturated_o,
  output logic                               last_out_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int SQW = 2 * CW;
  localparam int SW  = (SQW + 2 > 64) ? 64 : SQW + 2;   // sum of squares
  localparam int XW  = CW + GUARD_BITS + 3;             // cordic x/y
  localparam int AW  = 35;                              // cordic angle, q30
  localparam int RS  = 30 - ANGLE_FRAC_BITS;            // angle round shift
  localparam int SH  = 28 + LOG_FRAC + 1 - ANGLE_FRAC_BITS;
  localparam int PD  = ST_LOG - CORDIC_STEPS;           // phi wait for eta

  localparam logic signed [AW-1:0] PH_MAX = 35'sd16383;
  localparam logic signed [AW-1:0] PH_MIN = -35'sd16384;

  // valid line and side flags
  logic   vld_q [0:ST_OUT];
  flags_t flg_q [0:ST_OUT-1];

  // stage 0 input register
  logic signed [CW-1:0] x_q, y_q;
  logic        [CW-1:0] ax_q, ay_q;
  logic        [CW-1:0] az_q [0:ST_A-1];

  // stage 1 squares, stage 2 sums
  logic [SQW-1:0] ax2_q, ay2_q, az2_q;
  logic [SW-1:0]  r2_q [2:ST_A];
  logic [SW-1:0]  s3_q;

  // square root line
  logic [4:0]  k_q  [ST_K:ST_LOG];
  logic [63:0] nn_q [0:SQRT_STEPS];
  logic [63:0] rs_q [0:SQRT_STEPS];

  logic [63:0] a_q;
  logic [29:0] log_a, log_r;
  logic [31:0] d_q;
  logic [59:0] prod_q;

  // cordic line
  logic signed [XW-1:0]  cx_q [0:CORDIC_STEPS];
  logic signed [XW-1:0]  cy_q [0:CORDIC_STEPS];
  logic signed [AW-1:0]  ca_q [0:CORDIC_STEPS];
  logic signed [14:0]    ph_q [0:PD];

  assign busy_o = 1'b0;

  // ---------------- valid line, the only reset state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ST_OUT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
      for (int i = 1; i <= ST_OUT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------- stage 0: take the hit ----------------
  always_ff @(posedge clk_i) begin
    x_q      <= x_pos_i;
    y_q      <= y_pos_i;
    ax_q     <= x_pos_i[CW-1] ? CW'(-x_pos_i) : CW'(x_pos_i);
    ay_q     <= y_pos_i[CW-1] ? CW'(-y_pos_i) : CW'(y_pos_i);
    az_q[0]  <= z_pos_i[CW-1] ? CW'(-z_pos_i) : CW'(z_pos_i);
    flg_q[0] <= '{last:   last_hit_i,
                  z_pos:  !z_pos_i[CW-1] && (z_pos_i != '0),
                  z_neg:  z_pos_i[CW-1],
                  r_zero: (x_pos_i == '0) && (y_pos_i == '0)};
    for (int i = 1; i < ST_OUT; i++) flg_q[i] <= flg_q[i-1];
    for (int i = 1; i < ST_A; i++)   az_q[i]  <= az_q[i-1];
  end

  // ---------------- stages 1 and 2: squares and sums ----------------
  always_ff @(posedge clk_i) begin
    ax2_q   <= ax_q * ax_q;
    ay2_q   <= ay_q * ay_q;
    az2_q   <= az_q[0] * az_q[0];
    r2_q[2] <= SW'(ax2_q) + SW'(ay2_q);
    s3_q    <= SW'(ax2_q) + SW'(ay2_q) + SW'(az2_q);
    for (int i = 3; i <= ST_A; i++) r2_q[i] <= r2_q[i-1];
  end

  // ---------------- stage 3: scale so the square sits just under 2^62 ----------------
  logic [5:0] s3_top;
  logic [6:0] s3_len;
  logic [4:0] k_d;

  always_comb begin
    s3_top = '0;
    for (int b = 0; b < SW; b++) begin
      if (s3_q[b]) s3_top = 6'(b);
    end
    s3_len = 7'(s3_top) + 7'd1;
    k_d    = (s3_len < 7'd62) ? 5'((7'd62 - s3_len) >> 1) : 5'd0;
  end

  always_ff @(posedge clk_i) begin
    k_q[ST_K] <= k_d;
    nn_q[0]   <= 64'(s3_q) << {k_d, 1'b0};
    rs_q[0]   <= '0;
    for (int i = ST_K + 1; i <= ST_LOG; i++) k_q[i] <= k_q[i-1];
  end

  // ---------------- square root, one result bit per stage ----------------
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = rs_q[j] + BIT;
    always_ff @(posedge clk_i) begin
      if (nn_q[j] >= trial) begin
        nn_q[j+1] <= nn_q[j] - trial;
        rs_q[j+1] <= (rs_q[j] >> 1) + BIT;
      end else begin
        nn_q[j+1] <= nn_q[j];
        rs_q[j+1] <= rs_q[j] >> 1;
      end
    end
  end

  // ---------------- stage 36: sqrt(x^2+y^2+z^2) + |z|, both scaled by 2^k ----------------
  always_ff @(posedge clk_i) begin
    a_q <= rs_q[SQRT_STEPS] + (64'(az_q[ST_A-1]) << k_q[ST_A-1]);
  end

  // ---------------- log2 of both terms ----------------
  c2ep_log2 u_log_a (
    .clk_i (clk_i),
    .val_i (a_q),
    .log_o (log_a)
  );

  c2ep_log2 u_log_r (
    .clk_i (clk_i),
    .val_i (64'(r2_q[ST_A])),
    .log_o (log_r)
  );

  // ---------------- |eta| = ln2 * (2 log2 a - 2k - log2 r^2) / 2 ----------------
  logic signed [33:0] diff;

  assign diff = $signed({3'b000, log_a, 1'b0})
              - $signed({4'b0000, k_q[ST_LOG], 25'd0})
              - $signed({4'b0000, log_r});

  always_ff @(posedge clk_i) begin
    d_q    <= diff[33] ? 32'd0 : diff[31:0];
    prod_q <= d_q * LN2_Q28;
  end

  // ---------------- phi: quadrant fold then vectoring cordic ----------------
  logic signed [XW-1:0] xe, ye, fx, fy;
  logic signed [AW-1:0] fa;

  always_comb begin
    xe = XW'(x_q);
    ye = XW'(y_q);
    fx = xe;
    fy = ye;
    fa = '0;
    if (x_q[CW-1]) begin
      if (!y_q[CW-1]) begin
        fx = ye;
        fy = -xe;
        fa = $signed({4'b0000, PI_HALF_Q30});
      end else begin
        fx = -ye;
        fy = xe;
        fa = -$signed({4'b0000, PI_HALF_Q30});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0] <= fx <<< GUARD_BITS;
    cy_q[0] <= fy <<< GUARD_BITS;
    ca_q[0] <= fa;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    logic signed [AW-1:0] at;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    assign at = $signed({5'b00000, ATAN_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (!cy_q[i][XW-1]) begin
        cx_q[i+1] <= cx_q[i] + ys;
        cy_q[i+1] <= cy_q[i] - xs;
        ca_q[i+1] <= ca_q[i] + at;
      end else begin
        cx_q[i+1] <= cx_q[i] - ys;
        cy_q[i+1] <= cy_q[i] + xs;
        ca_q[i+1] <= ca_q[i] - at;
      end
    end
  end

  // round to the output grid, clamp, then wait for the eta path
  logic signed [AW-1:0] ph_sum, ph_shr;

  assign ph_sum = ca_q[CORDIC_STEPS] + (AW'(1) <<< (RS - 1));
  assign ph_shr = ph_sum >>> RS;

  always_ff @(posedge clk_i) begin
    if (ph_shr > PH_MAX) begin
      ph_q[0] <= 15'(PH_MAX);
    end else if (ph_shr < PH_MIN) begin
      ph_q[0] <= 15'(PH_MIN);
    end else begin
      ph_q[0] <= ph_shr[14:0];
    end
    for (int i = 1; i <= PD; i++) ph_q[i] <= ph_q[i-1];
  end

  // ---------------- output register ----------------
  flags_t             fo;
  logic [63:0]        rnd, mag;
  logic signed [15:0] eta_d;
  logic               sat_d;

  assign fo  = flg_q[ST_OUT-1];
  assign rnd = 64'(prod_q) + (64'd1 << (SH - 1));
  assign mag = rnd >> SH;

  always_comb begin
    eta_d = '0;
    sat_d = 1'b0;
    if (fo.r_zero) begin
      // on the beam axis the log diverges
      if (fo.z_pos) begin
        eta_d = ETA_POS_END;
        sat_d = 1'b1;
      end else if (fo.z_neg) begin
        eta_d = ETA_NEG_END;
        sat_d = 1'b1;
      end
    end else if (fo.z_pos) begin
      if (mag > 64'(ETA_POS_END)) begin
        eta_d = ETA_POS_END;
        sat_d = 1'b1;
      end else begin
        eta_d = mag[15:0];
      end
    end else if (fo.z_neg) begin
      if (mag > 64'd32768) begin
        eta_d = ETA_NEG_END;
        sat_d = 1'b1;
      end else begin
        eta_d = -mag[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eta_o           <= eta_d;
    eta_saturated_o <= sat_d;
    phi_o           <= fo.r_zero ? 15'sd0 : ph_q[PD];
    last_out_o      <= fo.last;
  end

  assign done_o = vld_q[ST_OUT];

endmodule

`default_nettype wire

// ===== hw/rtl/c2ep_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module c2ep_checker import c2ep_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          last_hit_i,
  input wire logic                          busy_o,
  input wire logic                          done_o,
  input wire logic signed [15:0]            eta_o,
  input wire logic signed [14:0]            phi_o,
  input wire logic                          eta_saturated_o,
  input wire logic                          last_out_o
);

  localparam int CNT_W   = $clog2(LATENCY + 1);
  localparam int PHI_RAW = int'(PI_Q30 >> (30 - ANGLE_FRAC_BITS)) + 1;
  localparam int PHI_LIM = (PHI_RAW > 16383) ? 16383 : PHI_RAW;

  logic [CNT_W-1:0] cnt_q;
  logic             armed;

  // cycles since reset, so history reaching into reset is not compared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != CNT_W'(LATENCY)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign armed = (cnt_q == CNT_W'(LATENCY));

  a_one_result_per_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed |-> (done_o == $past(start_i && !busy_o, LATENCY)))
    else $error("result strobe does not follow hit transfer");

  a_last_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed && done_o) |-> (last_out_o == $past(last_hit_i, LATENCY)))
    else $error("last mark lost on its way through");

  a_sat_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && eta_saturated_o) |-> (eta_o == 16'sh7FFF || eta_o == 16'sh8000))
    else $error("saturated eta not at a range end");

  a_phi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(phi_o) <= PHI_LIM && int'(phi_o) >= -PHI_LIM))
    else $error("phi beyond plus or minus pi");

endmodule

bind cartesian_to_eta_phi c2ep_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_c2ep_checker (.*);

`default_nettype wire
